[rtl/dmso_pkg.sv]
// ============================================================================
// dmso_pkg
// Shared types, codes and fixed-point helpers of the dense matrix store.
// ============================================================================
`default_nettype none

package dmso_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int DW           = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int CNT_W        = 5;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_SCALE = 3'd2;
    localparam logic [2:0] MODE_IDENT = 3'd3;
    localparam logic [2:0] MODE_VEC   = 3'd4;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_IDENT = 3'd3;
    localparam logic [2:0] OP_VEC   = 3'd4;
    localparam logic [2:0] OP_ERR   = 3'd5;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam logic signed [63:0] HALF_LSB =
        (FRAC_BITS > 0) ? (64'sd1 <<< (FRAC_BITS - 1)) : 64'sd0;
    localparam logic signed [63:0] ONE_SQ   = 64'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [63:0] I64_MAX  = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] I64_MIN  = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] DMAX     = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] DMIN     = -DMAX - 64'sd1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] scale;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [3:0]         out_row;
        logic               status;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] scale;
    } cmd_t;

    function automatic logic signed [DW-1:0] sat_data(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > DMAX)
        begin
            r = DW'(DMAX);
        end
        else if (v < DMIN)
        begin
            r = DW'(DMIN);
        end
        else
        begin
            r = DW'(v);
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] c;
        logic signed [63:0] s;
        c = (v > I64_MAX - HALF_LSB) ? (I64_MAX - HALF_LSB) : v;
        s = (c + HALF_LSB) >>> FRAC_BITS;
        return sat_data(s);
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
        begin
            r = s[64] ? I64_MIN : I64_MAX;
        end
        else
        begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/dmso_ram.sv]
// ============================================================================
// dmso_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module dmso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/dmso_front.sv]
// ============================================================================
// dmso_front
// Accepts items, checks their indexes and queues classified commands.
// ============================================================================
`default_nettype none

module dmso_front
    import dmso_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire in_item_t         cmd,
    input  wire logic [CNT_W-1:0] row_count,
    input  wire logic [CNT_W-1:0] col_count,
    input  wire logic             clearing,
    output logic                  q_valid,
    output cmd_t                  q_item,
    input  wire logic             q_pop
);

    cmd_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       row_ok, col_ok;
    cmd_t       cls;

    assign cmd_stall = (count_reg == 2'd2) || clearing;
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = entry_reg[rptr_reg];

    assign row_ok = ({1'b0, cmd.row} < row_count);
    assign col_ok = ({1'b0, cmd.col} < col_count);

    always_comb
    begin
        cls.row   = cmd.row;
        cls.col   = cmd.col;
        cls.value = cmd.value;
        cls.scale = cmd.scale;
        unique case (cmd.mode)
            MODE_WRITE: cls.op = (row_ok && col_ok) ? OP_WRITE : OP_ERR;
            MODE_READ:  cls.op = (row_ok && col_ok) ? OP_READ : OP_ERR;
            MODE_SCALE: cls.op = (row_ok && col_ok) ? OP_SCALE : OP_ERR;
            MODE_IDENT: cls.op = OP_IDENT;
            MODE_VEC:   cls.op = col_ok ? OP_VEC : OP_ERR;
            default:    cls.op = OP_ERR;
        endcase
    end

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (q_pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

[rtl/dmso_back.sv]
// ============================================================================
// dmso_back
// Executes queued commands on the matrix RAM and the accumulators.
// ============================================================================
`default_nettype none

module dmso_back
    import dmso_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] row_count,
    input  wire logic [CNT_W-1:0] col_count,
    output logic                  clearing,
    input  wire logic             q_valid,
    input  wire cmd_t             q_item,
    output logic                  q_pop,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output out_item_t             rsp
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_VEMIT = 4'd8;

    logic [3:0]             state_reg, state_next;
    cmd_t                   op_reg, op_next;
    logic [CNT_W-1:0]       ri_reg, ri_next;
    logic [CNT_W-1:0]       cj_reg, cj_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic signed [63:0]     prod_reg, prod_next;
    logic signed [63:0]     sum_reg, sum_next;
    logic signed [DW-1:0]   res_reg, res_next;
    logic signed [63:0]     acc_reg [MAX_ROWS];
    logic signed [63:0]     acc_next [MAX_ROWS];
    logic                   rsp_valid_reg, rsp_valid_next;
    out_item_t              rsp_reg, rsp_next;

    logic                   we;
    logic [AW-1:0]          waddr, raddr, cur_addr;
    logic signed [DW-1:0]   wdata, rdata, wb_val;
    logic signed [31:0]     mul_a;
    logic signed [63:0]     acc_cur;
    logic                   slot_free;
    logic                   last_row, last_col;

    dmso_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur_addr  = AW'(int'(ri_reg) * MAX_COLS + int'(cj_reg));
    assign raddr     = cur_addr;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign last_row  = (ri_reg == row_count - 5'd1);
    assign last_col  = (cj_reg == col_count - 5'd1);
    assign mul_a     = (op_reg.op == OP_VEC) ? op_reg.value : op_reg.scale;
    assign acc_cur   = acc_reg[RIW'(ri_reg)];
    assign wb_val    = round_sat(sum_reg);
    assign clearing  = (state_reg == S_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ri_next        = ri_reg;
        cj_next        = cj_reg;
        clr_next       = clr_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = cur_addr;
        wdata          = wb_val;

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    op_next = q_item;
                    ri_next = {1'b0, q_item.row};
                    cj_next = {1'b0, q_item.col};
                    unique case (q_item.op)
                        OP_WRITE:
                        begin
                            we         = 1'b1;
                            waddr      = AW'(int'(q_item.row) * MAX_COLS + int'(q_item.col));
                            wdata      = sat_data(64'(q_item.value));
                            res_next   = sat_data(64'(q_item.value));
                            state_next = S_EMIT;
                        end
                        OP_READ, OP_SCALE:
                        begin
                            state_next = S_RD;
                        end
                        OP_IDENT:
                        begin
                            ri_next    = '0;
                            cj_next    = '0;
                            state_next = S_RD;
                        end
                        OP_VEC:
                        begin
                            ri_next = '0;
                            if (q_item.col == 4'd0)
                            begin
                                for (int k = 0; k < MAX_ROWS; k++)
                                begin
                                    acc_next[k] = '0;
                                end
                            end
                            state_next = S_RD;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (op_reg.op == OP_READ)
                begin
                    res_next   = rdata;
                    state_next = S_EMIT;
                end
                else
                begin
                    prod_next  = 64'(mul_a) * 64'(rdata);
                    state_next = (op_reg.op == OP_VEC) ? S_ACC : S_SUM;
                end
            end
            S_SUM:
            begin
                if (op_reg.op == OP_SCALE)
                begin
                    sum_next = prod_reg + (64'(op_reg.value) <<< FRAC_BITS);
                end
                else
                begin
                    sum_next = prod_reg + ((ri_reg == cj_reg) ? ONE_SQ : 64'sd0);
                end
                state_next = S_WB;
            end
            S_WB:
            begin
                we = 1'b1;
                if (op_reg.op == OP_SCALE)
                begin
                    res_next   = wb_val;
                    state_next = S_EMIT;
                end
                else if (last_row)
                begin
                    ri_next = '0;
                    if (last_col)
                    begin
                        res_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cj_next    = cj_reg + 5'd1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    ri_next    = ri_reg + 5'd1;
                    state_next = S_RD;
                end
            end
            S_ACC:
            begin
                acc_next[RIW'(ri_reg)] = sat_add64(acc_cur, prod_reg);
                if (last_row)
                begin
                    ri_next    = '0;
                    state_next = last_col ? S_VEMIT : S_IDLE;
                end
                else
                begin
                    ri_next    = ri_reg + 5'd1;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.data  = 32'(res_reg);
                    rsp_next.last  = 1'b1;
                    rsp_next.status = (op_reg.op == OP_ERR);
                    rsp_next.out_row = (op_reg.op == OP_WRITE || op_reg.op == OP_READ ||
                                        op_reg.op == OP_SCALE) ? op_reg.row : 4'd0;
                    state_next = S_IDLE;
                end
            end
            S_VEMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.data    = 32'(round_sat(acc_cur));
                    rsp_next.out_row = 4'(ri_reg);
                    rsp_next.status  = 1'b0;
                    rsp_next.last    = last_row;
                    ri_next          = ri_reg + 5'd1;
                    if (last_row)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_ROWS; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        ri_reg   <= ri_next;
        cj_reg   <= cj_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

[rtl/dense_matrix_store_ops.sv]
// Steps: write and error S_EMIT; read S_RD, S_MUL, S_EMIT; scale-add element
// also S_SUM, S_WB; identity S_RD to S_WB per active element; vector element
// S_RD, S_MUL, S_ACC per active row, plus one result per cycle (unless rsp_stall
// holds) for the y rows on the last column. Items execute one at a time. Reset:
// a clearing pass over all MAX_ROWS*MAX_COLS words zeroes the RAM and holds off
// the input; accumulators clear at once; both counts reset to min(MAX_*, 16).
// ============================================================================
// dense_matrix_store_ops
// Dense matrix store with element access, scale-add and matrix-vector product.
// ============================================================================
`default_nettype none

module dense_matrix_store_ops
    import dmso_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire in_item_t    cmd,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output out_item_t        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [CNT_W-1:0] RESET_ROWS = CNT_W'((MAX_ROWS < 16) ? MAX_ROWS : 16);
    localparam logic [CNT_W-1:0] RESET_COLS = CNT_W'((MAX_COLS < 16) ? MAX_COLS : 16);

    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic             cfg_wr;
    logic             clearing;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_item;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v,
                                                   input int hi);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > hi)
        begin
            r = CNT_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROW_COUNT: row_count_next = clamp_dim(pwdata[CNT_W-1:0], MAX_ROWS);
                REG_COL_COUNT: col_count_next = clamp_dim(pwdata[CNT_W-1:0], MAX_COLS);
                default:       row_count_next = row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = {{(32 - CNT_W){1'b0}}, row_count_reg};
            REG_COL_COUNT: prdata = {{(32 - CNT_W){1'b0}}, col_count_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= RESET_ROWS;
            col_count_reg <= RESET_COLS;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    dmso_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    dmso_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
